/* rtl/core/depq_pkg.sv */
package depq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MIN = 2'd1,
        OP_DEL_MAX = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef struct packed {
        logic                     insert;
        logic                     shift_down;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

/* rtl/core/depq_cell.sv */
module depq_cell
    import depq_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic                     occupied,
    input  logic                     left_after,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    output logic                     after,
    output logic signed [DATA_W-1:0] val
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;

    // The cell is at or past the insertion point when it is empty or holds a larger value.
    assign after = !occupied || (cmd.value < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.insert && after)
        begin
            val_next = left_after ? left_val : cmd.value;
        end
        else if (cmd.shift_down)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* rtl/core/double_ended_priority_queue.sv */
// Timing: an accepted start is registered into busy (pend_reg), and busy into done (done_reg).
// No new operation is taken while busy; the row of cells updates at the accepting
// edge, and busy is high for the next cycle while the extreme values are picked from it.
// The receiver cannot stall; done lasts exactly one cycle.
// Reset (rst_n low, asynchronous) empties the queue and clears busy and done.
module double_ended_priority_queue
    import depq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  op,
    input  logic signed [DATA_W-1:0]    value,
    output logic                        done,
    output logic signed [DATA_W-1:0]    max_value,
    output logic signed [DATA_W-1:0]    min_value,
    output logic [OUT_CNT_W-1:0]        entry_count,
    output logic                        dropped
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     pend_reg;
    logic                     drop_pend_reg;
    logic                     drop_pend_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] max_value_reg;
    logic signed [DATA_W-1:0] min_value_reg;
    logic [OUT_CNT_W-1:0]     entry_count_reg;
    logic                     dropped_reg;

    logic                     accept;
    logic                     full;
    logic                     empty;
    op_t                      op_code;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] top_val;

    logic                     cell_after [CAPACITY];
    logic signed [DATA_W-1:0] cell_val   [CAPACITY];
    logic                     cell_occ   [CAPACITY];
    logic                     cell_top   [CAPACITY];

    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign op_code = op_t'(op);
    assign busy    = pend_reg;

    always_comb
    begin
        cmd.insert     = 1'b0;
        cmd.shift_down = 1'b0;
        cmd.value      = value;
        count_next     = count_reg;
        drop_pend_next = 1'b0;
        if (accept)
        begin
            unique case (op_code)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        drop_pend_next = 1'b1;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DEL_MIN:
                begin
                    if (!empty)
                    begin
                        cmd.shift_down = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                end
                OP_DEL_MAX:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < count_reg);
        assign cell_top[i] = (count_reg == CNT_W'(i + 1));

        if (i == 0)
        begin : g_first
            depq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (cell_occ[i]),
                .left_after (1'b0),
                .left_val   ('0),
                .right_val  (cell_val[(i + 1) % CAPACITY]),
                .after      (cell_after[i]),
                .val        (cell_val[i])
            );
        end
        else if (i == CAPACITY - 1)
        begin : g_last
            depq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (cell_occ[i]),
                .left_after (cell_after[i - 1]),
                .left_val   (cell_val[i - 1]),
                .right_val  (cell_val[i]),
                .after      (cell_after[i]),
                .val        (cell_val[i])
            );
        end
        else
        begin : g_mid
            depq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (cell_occ[i]),
                .left_after (cell_after[i - 1]),
                .left_val   (cell_val[i - 1]),
                .right_val  (cell_val[i + 1]),
                .after      (cell_after[i]),
                .val        (cell_val[i])
            );
        end
    end

    // Exactly one cell is marked as the top one when the queue is not empty.
    always_comb
    begin
        top_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            top_val = top_val | (cell_val[i] & {DATA_W{cell_top[i]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            pend_reg        <= 1'b0;
            drop_pend_reg   <= 1'b0;
            done_reg        <= 1'b0;
            dropped_reg     <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= accept;
            done_reg  <= pend_reg;
            if (accept)
            begin
                drop_pend_reg <= drop_pend_next;
            end
            if (pend_reg)
            begin
                dropped_reg     <= drop_pend_reg;
                entry_count_reg <= OUT_CNT_W'(count_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            max_value_reg <= empty ? '0 : top_val;
            min_value_reg <= empty ? '0 : cell_val[0];
        end
    end

    assign done        = done_reg;
    assign max_value   = max_value_reg;
    assign min_value   = min_value_reg;
    assign entry_count = entry_count_reg;
    assign dropped     = dropped_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pend_reg))
        else $error("Result strobe without an operation in progress.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("Accepted operation did not occupy the queue for one cycle.");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> full)
        else $error("Insert reported as dropped while the queue had room.");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !empty) |-> (max_value >= min_value))
        else $error("Reported maximum is below the reported minimum.");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import depq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic signed [DATA_W-1:0] max_v;
        logic signed [DATA_W-1:0] min_v;
        logic [OUT_CNT_W-1:0]     count;
        logic                     drop;
    } queue_status_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    op_t                      op_drv = OP_NOP;
    logic signed [DATA_W-1:0] value_drv = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     dropped;

    logic signed [DATA_W-1:0] held_values[$];
    queue_status_t            pending_status[$];
    queue_status_t            oldest_status;
    int                       error_count = 0;
    int                       idle_pct = 0;
    int                       stall_cycles = 0;

    double_ended_priority_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op_drv),
        .value       (value_drv),
        .done        (done),
        .max_value   (max_value),
        .min_value   (min_value),
        .entry_count (entry_count),
        .dropped     (dropped)
    );

    always #6 clk = ~clk;

    function automatic queue_status_t apply_queue_op(op_t o, logic signed [DATA_W-1:0] v);
        queue_status_t s;
        int            pos;
        s.drop = 1'b0;
        case (o)
            OP_INSERT:
            begin
                if (held_values.size() >= CAPACITY)
                begin
                    s.drop = 1'b1;
                end
                else
                begin
                    pos = held_values.size();
                    while (pos > 0 && v < held_values[pos-1])
                    begin
                        pos--;
                    end
                    held_values.insert(pos, v);
                end
            end
            OP_DEL_MIN:
            begin
                if (held_values.size() > 0)
                begin
                    void'(held_values.pop_front());
                end
            end
            OP_DEL_MAX:
            begin
                if (held_values.size() > 0)
                begin
                    void'(held_values.pop_back());
                end
            end
            default:
            begin
            end
        endcase
        if (held_values.size() == 0)
        begin
            s.max_v = '0;
            s.min_v = '0;
        end
        else
        begin
            s.max_v = held_values[held_values.size()-1];
            s.min_v = held_values[0];
        end
        s.count = OUT_CNT_W'(held_values.size());
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
        begin
            case ($urandom_range(4))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sh0;
                3: return -32'sh1;
                default: return 32'sh1;
            endcase
        end
        else if (sel <= 2)
        begin
            return $signed($urandom_range(15)) - 8;
        end
        return $urandom;
    endfunction

    task automatic send_op(op_t o, logic signed [DATA_W-1:0] v);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start     <= 1'b1;
        op_drv    <= o;
        value_drv <= v;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        pending_status.push_back(apply_queue_op(o, v));
    endtask

    task automatic compare_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, %s %0d %0d %0d %0b",
                         $time, "actual max, min, count, dropped", max_value, min_value,
                         entry_count, dropped);
                error_count++;
            end
            else
            begin
                oldest_status = pending_status.pop_front();
                compare_field("max_value", longint'(oldest_status.max_v), longint'(max_value));
                compare_field("min_value", longint'(oldest_status.min_v), longint'(min_value));
                compare_field("entry_count", longint'(oldest_status.count),
                              longint'(entry_count));
                compare_field("dropped", longint'(oldest_status.drop), longint'(dropped));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_empty_deletes();
        send_op(OP_DEL_MIN, 32'sh7FFFFFFF);
        send_op(OP_DEL_MAX, 32'sh80000000);
        send_op(OP_NOP, -32'sh1);
    endtask

    task automatic test_extreme_values();
        send_op(OP_INSERT, 32'sh7FFFFFFF);
        send_op(OP_INSERT, 32'sh80000000);
        send_op(OP_INSERT, 32'sh0);
        send_op(OP_INSERT, -32'sh1);
        send_op(OP_INSERT, 32'sh1);
        send_op(OP_INSERT, -32'sh1);
        send_op(OP_INSERT, 32'sh7FFFFFFF);
        send_op(OP_NOP, 32'sh12345678);
        send_op(OP_DEL_MAX, 32'sh0);
        send_op(OP_DEL_MIN, 32'sh0);
        send_op(OP_DEL_MAX, 32'sh0);
        send_op(OP_DEL_MIN, 32'sh0);
        send_op(OP_DEL_MIN, 32'sh0);
        send_op(OP_DEL_MAX, 32'sh0);
        send_op(OP_DEL_MAX, 32'sh0);
        send_op(OP_DEL_MIN, 32'sh0);
    endtask

    task automatic run_mixed_ops(int n_items, int insert_pct);
        int  sel;
        op_t o;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < insert_pct)
            begin
                o = OP_INSERT;
            end
            else
            begin
                sel = $urandom_range(19);
                o = (sel < 9) ? OP_DEL_MIN : (sel < 18) ? OP_DEL_MAX : OP_NOP;
            end
            send_op(o, pick_value());
        end
    endtask

    task automatic test_fill_and_drain();
        run_mixed_ops(100, 90);
        run_mixed_ops(100, 10);
        run_mixed_ops(170, 55);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 0;
        test_empty_deletes();
        test_extreme_values();

        idle_pct = 0;
        test_fill_and_drain();
        idle_pct = 49;
        test_fill_and_drain();
        idle_pct = 17;
        test_fill_and_drain();

        @(negedge clk);
        start <= 1'b0;
        while (pending_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
